@@ sv/alc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alc_pkg
// Shared constants, register codes and types for the average linkage
// clustering block.
// ----------------------------------------------------------------------------
package alc_pkg;

	localparam int MAX_OBJECTS_DEF = 64;
	localparam int DIST_BITS_DEF   = 16;

	localparam int IDX_W   = 6;
	localparam int DIN_W   = 16;
	localparam int LABEL_W = 7;
	localparam int OCNT_W  = 7;
	localparam int TCNT_W  = 6;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic REG_OBJECT_COUNT = 1'b0;
	localparam logic REG_TARGET_COUNT = 1'b1;

	localparam logic [OCNT_W-1:0] OBJECT_COUNT_RST = 7'd64;
	localparam logic [TCNT_W-1:0] TARGET_COUNT_RST = 6'd1;

	typedef struct packed {
		logic [OCNT_W-1:0] object_count;
		logic [TCNT_W-1:0] target_count;
	} cfg_t;

endpackage

@@ sv/alc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alc_in_if / alc_out_if
// Valid/ready channels for matrix entry beats and class label beats.
// ----------------------------------------------------------------------------
interface alc_in_if import alc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  row_index;
	logic [IDX_W-1:0]  col_index;
	logic [DIN_W-1:0]  distance_value;
	logic              last_entry;

	modport source (output valid, row_index, col_index, distance_value, last_entry,
		input ready);
	modport sink (input valid, row_index, col_index, distance_value, last_entry,
		output ready);
endinterface

interface alc_out_if import alc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [IDX_W-1:0]   object_index;
	logic [LABEL_W-1:0] class_label;
	logic               last_object;

	modport source (output valid, object_index, class_label, last_object, input ready);
	modport sink (input valid, object_index, class_label, last_object, output ready);
endinterface

@@ sv/alc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alc_ram
// Simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module alc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/alc_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alc_cfg
// APB register file: object count and target class count.
// ----------------------------------------------------------------------------
module alc_cfg import alc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic [OCNT_W-1:0] object_count_q;
	logic [TCNT_W-1:0] target_count_q;
	logic              wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			object_count_q <= OBJECT_COUNT_RST;
			target_count_q <= TARGET_COUNT_RST;
		end else if (wr) begin
			case (paddr[2])
				REG_OBJECT_COUNT: object_count_q <= pwdata[OCNT_W-1:0];
				REG_TARGET_COUNT: target_count_q <= pwdata[TCNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_OBJECT_COUNT: prdata = PDATA_W'(object_count_q);
			REG_TARGET_COUNT: prdata = PDATA_W'(target_count_q);
			default:          prdata = '0;
		endcase
	end

	assign cfg.object_count = object_count_q;
	assign cfg.target_count = target_count_q;

endmodule

@@ sv/alc_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alc_engine
// Load sequencer and merge search over the distance and label memories.
// ----------------------------------------------------------------------------
module alc_engine import alc_pkg::*; #(
	parameter int MAX_OBJECTS = MAX_OBJECTS_DEF,
	parameter int DIST_BITS   = DIST_BITS_DEF,
	localparam int IW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1,
	localparam int CW = $clog2(MAX_OBJECTS + 1),
	localparam int AW = $clog2(MAX_OBJECTS * MAX_OBJECTS),
	localparam int SW = DIST_BITS + CW,
	localparam int PW = SW + CW
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	alc_in_if.sink               item_in,
	alc_out_if.source            item_out,
	output logic                 dist_we,
	output logic [AW-1:0]        dist_waddr,
	output logic [DIST_BITS-1:0] dist_wdata,
	output logic [AW-1:0]        dist_raddr,
	input  logic [DIST_BITS-1:0] dist_rdata,
	output logic                 lab_we,
	output logic [IW-1:0]        lab_waddr,
	output logic [LABEL_W-1:0]   lab_wdata,
	output logic [IW-1:0]        lab_raddr,
	input  logic [LABEL_W-1:0]   lab_rdata
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_RINIT  = 4'd1;
	localparam logic [3:0] ST_ICHK   = 4'd2;
	localparam logic [3:0] ST_JCHK   = 4'd3;
	localparam logic [3:0] ST_SCAN   = 4'd4;
	localparam logic [3:0] ST_MUL    = 4'd5;
	localparam logic [3:0] ST_CMP    = 4'd6;
	localparam logic [3:0] ST_MERGE  = 4'd7;
	localparam logic [3:0] ST_OUTRD  = 4'd8;
	localparam logic [3:0] ST_OUTLD  = 4'd9;
	localparam logic [3:0] ST_OUTW   = 4'd10;

	logic [3:0]             state_q;
	logic [CW-1:0]          n_q, i_q, j_q, k_q, o_q;
	logic [TCNT_W-1:0]      rounds_q;
	logic                   v_s1;
	logic [IW-1:0]          k_s1;
	logic                   found_q;
	logic [IW-1:0]          best_rep_q, best_obj_q;
	logic [SW-1:0]          best_sum_q, sum_q;
	logic [CW-1:0]          best_cnt_q, cnt_q;
	logic [PW-1:0]          prod_a_q, prod_b_q;
	logic [MAX_OBJECTS-1:0] joined_q, merged_q;
	logic                   out_valid_q;
	logic [IDX_W-1:0]       out_idx_q;
	logic [LABEL_W-1:0]     out_lab_q;
	logic                   out_last_q;

	logic                   in_acc, out_acc;
	logic [OCNT_W-1:0]      n_sat;
	logic signed [8:0]      rnd;
	logic                   member;
	logic [IW-1:0]          i_ix, j_ix, k_ix, o_ix;

	assign i_ix = i_q[IW-1:0];
	assign j_ix = j_q[IW-1:0];
	assign k_ix = k_q[IW-1:0];
	assign o_ix = o_q[IW-1:0];

	assign item_in.ready = (state_q == ST_IDLE);
	assign in_acc  = item_in.valid && item_in.ready;
	assign out_acc = item_out.valid && item_out.ready;

	assign n_sat = (cfg.object_count > OCNT_W'(MAX_OBJECTS)) ? OCNT_W'(MAX_OBJECTS)
		: cfg.object_count;
	assign rnd = $signed({2'b00, n_sat}) - 9'sd1 - $signed({3'b000, cfg.target_count});

	assign dist_we = in_acc && (7'(item_in.row_index) < 7'(MAX_OBJECTS))
		&& (7'(item_in.col_index) < 7'(MAX_OBJECTS));
	assign dist_waddr = AW'(item_in.row_index * MAX_OBJECTS) + AW'(item_in.col_index);
	assign dist_wdata = DIST_BITS'(item_in.distance_value);
	assign dist_raddr = AW'(k_ix * MAX_OBJECTS) + AW'(j_ix);

	assign lab_we    = (state_q == ST_MERGE);
	assign lab_waddr = best_obj_q;
	assign lab_wdata = LABEL_W'(best_rep_q) + LABEL_W'(1);
	assign lab_raddr = (state_q == ST_SCAN) ? k_ix : o_ix;

	assign member = (k_s1 == i_ix)
		|| (joined_q[k_s1] && (lab_rdata == LABEL_W'(i_ix) + LABEL_W'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			o_q         <= '0;
			rounds_q    <= '0;
			v_s1        <= 1'b0;
			found_q     <= 1'b0;
			joined_q    <= '0;
			merged_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && item_in.last_entry) begin
						n_q      <= CW'(n_sat);
						rounds_q <= TCNT_W'(rnd);
						joined_q <= '0;
						merged_q <= '0;
						o_q      <= '0;
						state_q  <= (rnd > 9'sd0) ? ST_RINIT : ST_OUTRD;
					end
				end
				ST_RINIT: begin
					found_q <= 1'b0;
					i_q     <= '0;
					state_q <= ST_ICHK;
				end
				ST_ICHK: begin
					if (i_q == n_q) begin
						state_q <= found_q ? ST_MERGE : ST_OUTRD;
					end else if (joined_q[i_ix]) begin
						i_q <= i_q + CW'(1);
					end else begin
						j_q     <= '0;
						state_q <= ST_JCHK;
					end
				end
				ST_JCHK: begin
					if (j_q == n_q) begin
						i_q     <= i_q + CW'(1);
						state_q <= ST_ICHK;
					end else if (j_q == i_q || joined_q[j_ix] || merged_q[j_ix]) begin
						j_q <= j_q + CW'(1);
					end else begin
						k_q     <= '0;
						sum_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					v_s1 <= (k_q != n_q);
					k_s1 <= k_ix;
					if (k_q != n_q) begin
						k_q <= k_q + CW'(1);
					end
					if (v_s1 && member) begin
						sum_q <= sum_q + SW'(dist_rdata);
						cnt_q <= cnt_q + CW'(1);
					end
					if (k_q == n_q && !v_s1) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_a_q <= PW'(sum_q * best_cnt_q);
					prod_b_q <= PW'(best_sum_q * cnt_q);
					state_q  <= ST_CMP;
				end
				ST_CMP: begin
					if (!found_q || prod_a_q < prod_b_q) begin
						found_q    <= 1'b1;
						best_sum_q <= sum_q;
						best_cnt_q <= cnt_q;
						best_rep_q <= i_ix;
						best_obj_q <= j_ix;
					end
					j_q     <= j_q + CW'(1);
					state_q <= ST_JCHK;
				end
				ST_MERGE: begin
					joined_q[best_obj_q] <= 1'b1;
					merged_q[best_rep_q] <= 1'b1;
					rounds_q <= rounds_q - TCNT_W'(1);
					state_q  <= (rounds_q == TCNT_W'(1)) ? ST_OUTRD : ST_RINIT;
				end
				ST_OUTRD: begin
					state_q <= (o_q == n_q) ? ST_IDLE : ST_OUTLD;
				end
				ST_OUTLD: begin
					out_valid_q <= 1'b1;
					out_idx_q   <= IDX_W'(o_q);
					out_lab_q   <= joined_q[o_ix] ? lab_rdata : LABEL_W'(o_q) + LABEL_W'(1);
					out_last_q  <= (o_q + CW'(1) == n_q);
					state_q     <= ST_OUTW;
				end
				ST_OUTW: begin
					if (out_acc) begin
						out_valid_q <= 1'b0;
						o_q         <= o_q + CW'(1);
						state_q     <= ST_OUTRD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign item_out.valid        = out_valid_q;
	assign item_out.object_index = out_idx_q;
	assign item_out.class_label  = out_lab_q;
	assign item_out.last_object  = out_last_q;

	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		item_out.valid |-> !item_in.ready)
		else $error("result pending while accepting input");
	a_merge_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE) |-> found_q && (best_rep_q != best_obj_q))
		else $error("merge without a valid pair");
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (k_q <= n_q) && (j_q < n_q) && (i_q < n_q))
		else $error("scan counters out of range");
	a_merge_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE) |=> joined_q[$past(best_obj_q)] && merged_q[$past(best_rep_q)])
		else $error("merge not recorded");

endmodule

@@ sv/average_linkage_clustering.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// average_linkage_clustering
// Average linkage clustering over a loaded distance matrix.
// ----------------------------------------------------------------------------
// Matrix entries are taken one beat per cycle while idle. A beat with
// last_entry starts clustering: each round walks every (class, singleton)
// pair and, for each, reads the distance and label memories once per object.
// Labels are then returned one beat per object, each held until accepted.
// No entry beats are taken until the last label beat is accepted.
module average_linkage_clustering import alc_pkg::*; #(
	parameter int MAX_OBJECTS = MAX_OBJECTS_DEF,
	parameter int DIST_BITS   = DIST_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	alc_in_if.sink             item_in,
	alc_out_if.source          item_out
);

	localparam int IW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
	localparam int AW = $clog2(MAX_OBJECTS * MAX_OBJECTS);

	cfg_t                 cfg;
	logic                 dist_we;
	logic [AW-1:0]        dist_waddr, dist_raddr;
	logic [DIST_BITS-1:0] dist_wdata, dist_rdata;
	logic                 lab_we;
	logic [IW-1:0]        lab_waddr, lab_raddr;
	logic [LABEL_W-1:0]   lab_wdata, lab_rdata;

	alc_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.cfg
	);

	alc_ram #(.WIDTH(DIST_BITS), .DEPTH(MAX_OBJECTS * MAX_OBJECTS)) u_dist_ram (
		.clk, .we(dist_we), .waddr(dist_waddr), .wdata(dist_wdata),
		.raddr(dist_raddr), .rdata(dist_rdata)
	);

	alc_ram #(.WIDTH(LABEL_W), .DEPTH(MAX_OBJECTS)) u_lab_ram (
		.clk, .we(lab_we), .waddr(lab_waddr), .wdata(lab_wdata),
		.raddr(lab_raddr), .rdata(lab_rdata)
	);

	alc_engine #(.MAX_OBJECTS(MAX_OBJECTS), .DIST_BITS(DIST_BITS)) u_engine (
		.clk, .arst_n, .cfg, .item_in, .item_out,
		.dist_we, .dist_waddr, .dist_wdata, .dist_raddr, .dist_rdata,
		.lab_we, .lab_waddr, .lab_wdata, .lab_raddr, .lab_rdata
	);

endmodule
